// ----- hw/rtl/bounded_stack_engine_assert.svh -----
// Assertion macros for the stack engine. The enclosing module must provide
// clk_i and rst_ni; checks are suspended while reset is asserted.
`ifndef BOUNDED_STACK_ENGINE_ASSERT_SVH
`define BOUNDED_STACK_ENGINE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BSE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BSE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/bse_pkg.sv -----
package bse_pkg;

  localparam int unsigned DepthDef = 16;
  localparam int unsigned DataW    = 32;
  localparam int unsigned KindW    = 3;
  localparam int unsigned StatusW  = 2;

  // Request opcodes. Code 7 is unused and treated as a no-op.
  typedef enum logic [KindW-1:0] {
    K_PUSH,
    K_POP,
    K_PEEK,
    K_MIN,
    K_MAX,
    K_REV,
    K_SORT
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK,
    ST_FULL,
    ST_EMPTY
  } status_e;

  typedef struct packed {
    kind_e                   kind;
    logic signed [DataW-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [DataW-1:0] data;
    status_e                 status;
  } res_t;

endpackage

// ----- hw/rtl/bounded_stack_engine.sv -----
// Bounded LIFO stack of signed 32-bit words with push, pop, peek, minimum and
// maximum scans, in-place reversal and an ascending sort (bottom to top).
// The request channel (in_valid_i / in_stall_o) carries an opcode and a push
// word; a request is taken on a rising edge with valid high and stall low.
// Each request gives exactly one result on the result channel
// (out_valid_o / out_stall_i): data word, status, entry count and flags.
// All work goes through one stack memory (one write and one registered read
// port per cycle) and one shared signed comparator, run by a sequencer; the
// engine holds in_stall_o high until the current request has finished.
// Push, no-op, the empty-stack cases and reverse and sort of fewer than two
// words need no memory read; pop and peek wait on the registered memory read;
// min and max read the n stored words one at a time through the comparator;
// reverse swaps word pairs from both ends inward; sort is an insertion sort
// that shifts each larger neighbor up one slot. A new request can be taken
// as soon as the previous result has moved into the output register, even
// while it waits there.
// When out_stall_i is high the finished result is held steady in the output
// register, and a following request waits in its last step until it clears.
// Reset empties the stack and drops any pending result; no clearing is run.
`include "bounded_stack_engine_assert.svh"

module bounded_stack_engine #(
  parameter int unsigned DEPTH = bse_pkg::DepthDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [bse_pkg::KindW-1:0]           in_kind_i,
  input  logic signed [bse_pkg::DataW-1:0]    in_value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [bse_pkg::DataW-1:0]    out_data_o,
  output logic [bse_pkg::StatusW-1:0]         out_status_o,
  output logic [$clog2(DEPTH+1)-1:0]          out_entries_o,
  output logic                                out_is_empty_o,
  output logic                                out_is_full_o
);
  import bse_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic            core_idle, core_done, out_free, accept;
  req_t            req;
  res_t            core_res;
  logic [CntW-1:0] core_cnt;

  // Output register state.
  logic            out_valid_q;
  res_t            out_res_q;
  logic [CntW-1:0] out_cnt_q;
  logic            out_empty_q;
  logic            out_full_q;

  // The engine takes a request only while its sequencer is idle; the
  // output register decouples it from a stalled receiver.
  assign in_stall_o = !core_idle;
  assign accept     = in_valid_i && !in_stall_o;
  assign req        = '{kind: kind_e'(in_kind_i), value: in_value_i};

  // The output register can take a new result when it is empty or when its
  // current result is being taken in this cycle.
  assign out_free = !out_valid_q || !out_stall_i;

  bse_core #(
    .DEPTH(DEPTH)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .req_i      (req),
    .res_ready_i(out_free),
    .idle_o     (core_idle),
    .done_o     (core_done),
    .res_o      (core_res),
    .cnt_o      (core_cnt)
  );

  // The flags are derived from the count after the operation, as it is
  // loaded into the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_res_q   <= '{data: '0, status: ST_OK};
      out_cnt_q   <= '0;
      out_empty_q <= 1'b1;
      out_full_q  <= 1'b0;
    end else if (core_done && out_free) begin
      out_valid_q <= 1'b1;
      out_res_q   <= core_res;
      out_cnt_q   <= core_cnt;
      out_empty_q <= (core_cnt == '0);
      out_full_q  <= (core_cnt == CntW'(DEPTH));
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_res_q.data;
  assign out_status_o   = out_res_q.status;
  assign out_entries_o  = out_cnt_q;
  assign out_is_empty_o = out_empty_q;
  assign out_is_full_o  = out_full_q;

  // Every accepted request leaves the sequencer busy in the cycle after acceptance.
  `BSE_ASSERT_NXT(a_busy_after_accept, accept, in_stall_o, "engine idle after accept")
  // An empty-stack result carries the all-ones word and the empty flag.
  `BSE_ASSERT_NOW(a_empty_result, out_valid_o && out_status_o == ST_EMPTY,
                  out_data_o == '1 && out_is_empty_o && out_entries_o == '0,
                  "bad empty-stack result")
  // A refused push is only reported against a full stack.
  `BSE_ASSERT_NOW(a_full_result, out_valid_o && out_status_o == ST_FULL,
                  out_is_full_o && out_entries_o == CntW'(DEPTH),
                  "refused push on non-full stack")

endmodule

// ----- hw/rtl/bse_core.sv -----
module bse_core #(
  parameter int unsigned DEPTH = bse_pkg::DepthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  bse_pkg::req_t                req_i,
  input  logic                         res_ready_i,
  output logic                         idle_o,
  output logic                         done_o,
  output bse_pkg::res_t                res_o,
  output logic [$clog2(DEPTH+1)-1:0]   cnt_o
);
  import bse_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned AW   = $clog2(DEPTH);

  typedef enum logic [3:0] {
    S_IDLE,
    S_RDW,
    S_SCAN,
    S_REV_RHI,
    S_REV_WLO,
    S_REV_WHI,
    S_SRT_LD,
    S_SRT_CMP,
    S_SRT_PUT,
    S_DONE
  } state_e;

  state_e                  state_q, state_d;
  kind_e                   kind_q, kind_d;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic [CntW-1:0]         idx_q, idx_d;
  logic [CntW-1:0]         jdx_q, jdx_d;
  logic signed [DataW-1:0] key_q, key_d;
  logic signed [DataW-1:0] data_q, data_d;
  status_e                 status_q, status_d;

  logic signed [DataW-1:0] mem_q [DEPTH];
  logic signed [DataW-1:0] rd_q;
  logic                    we, re;
  logic [AW-1:0]           waddr, raddr;
  logic signed [DataW-1:0] wdata;

  logic [CntW-1:0]         cnt_dec, idx_inc, idx_dec, jdx_dec;
  logic signed [DataW-1:0] cmp_a, cmp_b;
  logic                    cmp_gt;

  assign cnt_dec = cnt_q - CntW'(1);
  assign idx_inc = idx_q + CntW'(1);
  assign idx_dec = idx_q - CntW'(1);
  assign jdx_dec = jdx_q - CntW'(1);

  // The single signed comparator shared by the scans and the sort.
  always_comb begin
    if (state_q == S_SCAN && kind_q == K_MIN) begin
      cmp_a = data_q;
      cmp_b = rd_q;
    end else if (state_q == S_SCAN) begin
      cmp_a = rd_q;
      cmp_b = data_q;
    end else begin
      cmp_a = rd_q;
      cmp_b = key_q;
    end
  end
  assign cmp_gt = cmp_a > cmp_b;

  always_comb begin
    state_d  = state_q;
    kind_d   = kind_q;
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    jdx_d    = jdx_q;
    key_d    = key_q;
    data_d   = data_q;
    status_d = status_q;
    we       = 1'b0;
    re       = 1'b0;
    waddr    = idx_q[AW-1:0];
    raddr    = idx_q[AW-1:0];
    wdata    = rd_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          kind_d   = req_i.kind;
          data_d   = '0;
          status_d = ST_OK;
          state_d  = S_DONE;
          case (req_i.kind)
            K_PUSH: begin
              if (cnt_q == CntW'(DEPTH)) begin
                status_d = ST_FULL;
              end else begin
                we    = 1'b1;
                waddr = cnt_q[AW-1:0];
                wdata = req_i.value;
                cnt_d = cnt_q + CntW'(1);
              end
            end
            K_POP, K_PEEK, K_MIN, K_MAX: begin
              if (cnt_q == '0) begin
                data_d   = '1;
                status_d = ST_EMPTY;
              end else if (req_i.kind == K_POP || req_i.kind == K_PEEK) begin
                re      = 1'b1;
                raddr   = cnt_dec[AW-1:0];
                state_d = S_RDW;
                if (req_i.kind == K_POP) begin
                  cnt_d = cnt_dec;
                end
              end else begin
                re      = 1'b1;
                raddr   = '0;
                idx_d   = '0;
                state_d = S_SCAN;
              end
            end
            K_REV: begin
              if (cnt_q > CntW'(1)) begin
                re      = 1'b1;
                raddr   = '0;
                idx_d   = '0;
                jdx_d   = cnt_dec;
                state_d = S_REV_RHI;
              end
            end
            K_SORT: begin
              if (cnt_q > CntW'(1)) begin
                re      = 1'b1;
                raddr   = AW'(1);
                idx_d   = CntW'(1);
                state_d = S_SRT_LD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_RDW: begin
        data_d  = rd_q;
        state_d = S_DONE;
      end
      S_SCAN: begin
        if (idx_q == '0 || cmp_gt) begin
          data_d = rd_q;
        end
        idx_d = idx_inc;
        if (idx_inc == cnt_q) begin
          state_d = S_DONE;
        end else begin
          re    = 1'b1;
          raddr = idx_inc[AW-1:0];
        end
      end
      S_REV_RHI: begin
        key_d   = rd_q;
        re      = 1'b1;
        raddr   = jdx_q[AW-1:0];
        state_d = S_REV_WLO;
      end
      S_REV_WLO: begin
        we      = 1'b1;
        waddr   = idx_q[AW-1:0];
        wdata   = rd_q;
        state_d = S_REV_WHI;
      end
      S_REV_WHI: begin
        we    = 1'b1;
        waddr = jdx_q[AW-1:0];
        wdata = key_q;
        idx_d = idx_inc;
        jdx_d = jdx_dec;
        if (idx_inc < jdx_dec) begin
          re      = 1'b1;
          raddr   = idx_inc[AW-1:0];
          state_d = S_REV_RHI;
        end else begin
          state_d = S_DONE;
        end
      end
      S_SRT_LD: begin
        key_d   = rd_q;
        jdx_d   = idx_q;
        re      = 1'b1;
        raddr   = idx_dec[AW-1:0];
        state_d = S_SRT_CMP;
      end
      S_SRT_CMP: begin
        // Shift the larger neighbor up one slot and keep walking down.
        if (cmp_gt) begin
          we    = 1'b1;
          waddr = jdx_q[AW-1:0];
          wdata = rd_q;
          jdx_d = jdx_dec;
          if (jdx_dec == '0) begin
            state_d = S_SRT_PUT;
          end else begin
            re    = 1'b1;
            raddr = jdx_dec[AW-1:0] - AW'(1);
          end
        end else begin
          state_d = S_SRT_PUT;
        end
      end
      S_SRT_PUT: begin
        we    = 1'b1;
        waddr = jdx_q[AW-1:0];
        wdata = key_q;
        idx_d = idx_inc;
        if (idx_inc == cnt_q) begin
          state_d = S_DONE;
        end else begin
          re      = 1'b1;
          raddr   = idx_inc[AW-1:0];
          state_d = S_SRT_LD;
        end
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      kind_q   <= K_PUSH;
      cnt_q    <= '0;
      idx_q    <= '0;
      jdx_q    <= '0;
      key_q    <= '0;
      data_q   <= '0;
      status_q <= ST_OK;
    end else begin
      state_q  <= state_d;
      kind_q   <= kind_d;
      cnt_q    <= cnt_d;
      idx_q    <= idx_d;
      jdx_q    <= jdx_d;
      key_q    <= key_d;
      data_q   <= data_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rd_q <= mem_q[raddr];
    end
  end

  assign idle_o = (state_q == S_IDLE);
  assign done_o = (state_q == S_DONE);
  assign res_o  = '{data: data_q, status: status_q};
  assign cnt_o  = cnt_q;

endmodule
